[rtl/wosr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wosr_pkg
// Shared types, sizes and codes of the soft-ramp waveform oscillator.
// ----------------------------------------------------------------------------
package wosr_pkg;

  // Sizing of the phase accumulator, the sine table and the mix words
  localparam int PHASE_BITS       = 24;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int MIX_BITS         = 24;
  localparam int MIX_SUM_BITS     = MIX_BITS + 2;

  // Fixed widths of the transaction fields
  localparam int FIELD_BITS  = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int WAVE_BITS   = SAMPLE_BITS + 1;

  // Shared multiplier operand and product widths
  localparam int MUL_A_BITS = 2 * WAVE_BITS;
  localparam int MUL_B_BITS = SAMPLE_BITS + 1;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

  // Q1.15 constants and the ramp step (0.025 in Q1.15)
  localparam logic [15:0] UNITY     = 16'd32768;
  localparam logic [15:0] RAMP_STEP = 16'd819;

  // Configuration register indexes
  localparam logic [1:0] REG_WAVEFORM   = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [1:0] REG_GAIN       = 2'd2;

  // Waveform codes
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SAW      = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] left_in;
    logic signed [FIELD_BITS-1:0] right_in;
    logic                         block_start;
    logic                         soft_start;
    logic                         soft_stop;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0]  left_out;
    logic signed [FIELD_BITS-1:0]  right_out;
    logic signed [SAMPLE_BITS-1:0] wave_sample;
  } out_item_t;

  // Operand load request to the shared multiplier
  typedef struct packed {
    logic                         load;
    logic signed [MUL_A_BITS-1:0] a;
    logic signed [MUL_B_BITS-1:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

[rtl/wosr_wave.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wosr_wave
// Waveform lookup: maps the phase to a Q1.15 sine, saw, square or triangle
// point in -32768..32768 and registers it on load.
// ----------------------------------------------------------------------------
module wosr_wave (
  input  wire logic                                 clk,
  input  wire logic                                 load,
  input  wire logic [wosr_pkg::PHASE_BITS-1:0]      phase,
  input  wire logic [1:0]                           waveform,
  output logic signed [wosr_pkg::WAVE_BITS-1:0]     wave
);
  import wosr_pkg::*;

  localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_BITS  = IDX_BITS - 2;
  localparam int QTR_DEPTH = SINE_TABLE_DEPTH / 4;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam logic [PHASE_BITS-1:0] HALF_PHASE = {1'b1, {(PHASE_BITS-1){1'b0}}};

  typedef logic [QTR_DEPTH-1:0][15:0] sine_rom_t;

  // Quarter-wave sine point k of QTR_DEPTH, Q30 Taylor series, rounded to Q1.15
  function automatic logic [15:0] sine_quarter(input longint unsigned k);
    longint unsigned a, x, x2, t, s, v;
    a  = k << (32 - IDX_BITS);
    x  = (a * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    v  = (s + (64'd1 << 14)) >> 15;
    return v[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int k = 0; k < QTR_DEPTH; k++) begin
      r[k] = sine_quarter(longint'(k));
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  // Quarter-wave end point (the crest), kept apart from the table
  localparam logic [15:0] SINE_PEAK = sine_quarter(longint'(QTR_DEPTH));

  logic [PHASE_BITS+IDX_BITS-1:0] idx_scaled;
  logic [PHASE_BITS+15:0]         top_scaled;
  logic [IDX_BITS-1:0]            sidx;
  logic [1:0]                     quad;
  logic [QTR_BITS:0]              qidx;
  logic [15:0]                    qval;
  logic [15:0]                    f16;
  logic signed [WAVE_BITS:0]      tri_offset;
  logic signed [WAVE_BITS:0]      tri_mag;
  logic signed [WAVE_BITS:0]      wide_val;
  logic signed [WAVE_BITS-1:0]    wave_sel;

  // Table index and top 16 phase bits, for any phase width
  always_comb begin
    idx_scaled = {phase, {IDX_BITS{1'b0}}};
    top_scaled = {phase, 16'd0};
    sidx       = idx_scaled[PHASE_BITS+IDX_BITS-1 -: IDX_BITS];
    f16        = top_scaled[PHASE_BITS+15 -: 16];
    quad       = sidx[IDX_BITS-1 -: 2];
    qidx       = quad[0] ? (QTR_BITS+1)'(QTR_DEPTH) - {1'b0, sidx[QTR_BITS-1:0]}
                         : {1'b0, sidx[QTR_BITS-1:0]};
    qval       = qidx[QTR_BITS] ? SINE_PEAK : SINE_ROM[qidx[QTR_BITS-1:0]];
    tri_offset = $signed({2'b00, f16}) - $signed((WAVE_BITS+1)'(UNITY));
    tri_mag    = tri_offset[WAVE_BITS] ? -tri_offset : tri_offset;
  end

  // Select the waveform point
  always_comb begin
    wide_val = '0;
    unique case (waveform)
      WAVE_SINE: begin
        wide_val = quad[1] ? -$signed({2'b00, qval}) : $signed({2'b00, qval});
      end
      WAVE_SAW: begin
        wide_val = $signed((WAVE_BITS+1)'(UNITY)) - $signed({2'b00, f16});
      end
      WAVE_SQUARE: begin
        wide_val = (phase <= HALF_PHASE) ? $signed((WAVE_BITS+1)'(UNITY))
                                         : -$signed((WAVE_BITS+1)'(UNITY));
      end
      WAVE_TRIANGLE: begin
        wide_val = (tri_mag <<< 1) - $signed((WAVE_BITS+1)'(UNITY));
      end
      default: wide_val = '0;
    endcase
    wave_sel = wide_val[WAVE_BITS-1:0];
  end

  // Hold the point for the multiply steps
  always_ff @(posedge clk) begin
    if (load) begin
      wave <= wave_sel;
    end
  end

endmodule
`default_nettype wire

[rtl/wosr_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wosr_mul
// Shared signed multiplier with a registered product, used once for
// wave times damping and once for that product times gain.
// ----------------------------------------------------------------------------
module wosr_mul (
  input  wire logic                                  clk,
  input  wire wosr_pkg::mul_req_t                    req,
  output logic signed [wosr_pkg::MUL_P_BITS-1:0]     prod
);
  import wosr_pkg::*;

  logic signed [MUL_P_BITS-1:0] prod_next;

  // Multiply the sign-extended operands
  always_comb begin
    prod_next = MUL_P_BITS'(req.a) * MUL_P_BITS'(req.b);
  end

  // Hold the product until the next load
  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= prod_next;
    end
  end

endmodule
`default_nettype wire

[rtl/waveform_oscillator_soft_ramp_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_oscillator_soft_ramp_core
// Phase-accumulator oscillator with soft start/stop ramp, added into a mix.
// ----------------------------------------------------------------------------
// Each input transaction is one frame tick: left and right mix samples plus
// a block-start flag with soft-start and soft-stop requests. The block adds
// the scaled oscillator sample into both channels with saturation and
// returns them with the sample itself as one output transaction.
// The cfg channel writes waveform, phase step and gain; the user must write
// them only while the block is idle, which the block itself does not enforce;
// cfg_ready is always high. For each item the sequencer steps through the
// wave lookup, two passes through the shared multiplier, rounding, then the
// left and right saturating adds through one adder, and raises out_valid on
// the final mix step.
// in_ready is high only while the sequencer is idle. A finished result
// waits in the output register; the next item is accepted meanwhile, and
// its final step holds until the output register is taken.
// Reset (synchronous) clears phase, sets damping and ramp target to unity
// with no ramp, and restores the register defaults; no sweep is needed.
// ----------------------------------------------------------------------------
module waveform_oscillator_soft_ramp_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire wosr_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output wosr_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [wosr_pkg::FIELD_BITS-1:0] cfg_data
);
  import wosr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WAVE, ST_MUL1, ST_MUL2, ST_SCALE, ST_MIXL, ST_MIXR
  } state_t;

  typedef enum logic [1:0] {
    RAMP_NONE, RAMP_UP, RAMP_DOWN
  } ramp_t;

  localparam int Q_SHIFT = 30;
  localparam logic signed [MUL_P_BITS:0] ROUND_HALF =
    (MUL_P_BITS+1)'(64'sd1 <<< (Q_SHIFT - 1));
  localparam logic signed [MUL_P_BITS:0] SAMPLE_MAX = (MUL_P_BITS+1)'(32767);
  localparam logic signed [MUL_P_BITS:0] SAMPLE_MIN = -(MUL_P_BITS+1)'(32768);
  localparam logic signed [MIX_SUM_BITS-1:0] MIX_MAX =
    MIX_SUM_BITS'((64'sd1 <<< (MIX_BITS - 1)) - 64'sd1);
  localparam logic signed [MIX_SUM_BITS-1:0] MIX_MIN = -MIX_MAX - MIX_SUM_BITS'(1);
  localparam logic signed [17:0] STEP_S = 18'($unsigned(RAMP_STEP));

  state_t                         state;
  ramp_t                          ramp_dir;
  logic [1:0]                     waveform;
  logic [FIELD_BITS-1:0]          phase_step;
  logic [15:0]                    gain;
  logic [PHASE_BITS-1:0]          phase;
  logic [15:0]                    damping;
  logic [15:0]                    damping_next;
  logic [15:0]                    ramp_target;
  logic signed [FIELD_BITS-1:0]   left_in;
  logic signed [FIELD_BITS-1:0]   right_in;
  logic signed [FIELD_BITS-1:0]   left_sum;
  logic signed [SAMPLE_BITS-1:0]  scaled;
  logic signed [SAMPLE_BITS-1:0]  scaled_next;
  logic signed [WAVE_BITS-1:0]    wave;
  logic signed [MUL_P_BITS-1:0]   prod;
  mul_req_t                       mul_req;
  logic signed [MUL_P_BITS:0]     rnd_sum;
  logic signed [MUL_P_BITS:0]     rnd_q;
  logic signed [17:0]             ramp_rem;
  logic signed [17:0]             ramp_nd;
  logic [FIELD_BITS-1:0]          mix_sel;
  logic signed [MIX_BITS-1:0]     mix_word;
  logic signed [MIX_SUM_BITS-1:0] mix_add;
  logic signed [MIX_SUM_BITS-1:0] mix_sum;
  logic signed [MIX_SUM_BITS-1:0] mix_sat;
  logic signed [FIELD_BITS-1:0]   mix_res;
  logic                           out_free;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  wosr_wave u_wave (
    .clk      (clk),
    .load     (state == ST_WAVE),
    .phase    (phase),
    .waveform (waveform),
    .wave     (wave)
  );

  // Route operands to the shared multiplier
  always_comb begin
    mul_req.load = (state == ST_MUL1) || (state == ST_MUL2);
    mul_req.a    = MUL_A_BITS'(wave);
    mul_req.b    = $signed({1'b0, damping});
    if (state == ST_MUL2) begin
      mul_req.a = prod[MUL_A_BITS-1:0];
      mul_req.b = $signed({1'b0, gain});
    end
  end

  wosr_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // Round the Q45 product to Q1.15 and saturate
  always_comb begin
    rnd_sum = (MUL_P_BITS+1)'(prod) + ROUND_HALF;
    rnd_q   = rnd_sum >>> Q_SHIFT;
    priority if (rnd_q > SAMPLE_MAX) begin
      scaled_next = 16'sh7fff;
    end else if (rnd_q < SAMPLE_MIN) begin
      scaled_next = -16'sh7fff - 16'sh0001;
    end else begin
      scaled_next = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  // Step the damping ramp while far enough from its target
  always_comb begin
    ramp_rem     = $signed({2'b00, ramp_target}) - $signed({2'b00, damping});
    ramp_nd      = (ramp_dir == RAMP_UP) ? $signed({2'b00, damping}) + STEP_S
                                         : $signed({2'b00, damping}) - STEP_S;
    damping_next = damping;
    if ((ramp_rem >= STEP_S || ramp_rem <= -STEP_S) &&
        (ramp_dir == RAMP_UP || ramp_dir == RAMP_DOWN)) begin
      priority if (ramp_nd < 18'sd0) begin
        damping_next = 16'd0;
      end else if (ramp_nd > 18'sd65535) begin
        damping_next = 16'hffff;
      end else begin
        damping_next = ramp_nd[15:0];
      end
    end
  end

  // Shared saturating adder: left channel first, then right
  always_comb begin
    mix_sel  = (state == ST_MIXL) ? $unsigned(left_in) : $unsigned(right_in);
    mix_word = MIX_BITS'(mix_sel);
    mix_add  = MIX_SUM_BITS'(scaled) <<< (MIX_BITS - SAMPLE_BITS);
    mix_sum  = MIX_SUM_BITS'(mix_word) + mix_add;
    priority if (mix_sum > MIX_MAX) begin
      mix_sat = MIX_MAX;
    end else if (mix_sum < MIX_MIN) begin
      mix_sat = MIX_MIN;
    end else begin
      mix_sat = mix_sum;
    end
    mix_res = FIELD_BITS'(mix_sat);
  end

  // Sequencer, oscillator state, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      waveform    <= WAVE_SINE;
      phase_step  <= FIELD_BITS'(153919);
      gain        <= UNITY;
      phase       <= '0;
      damping     <= UNITY;
      ramp_dir    <= RAMP_NONE;
      ramp_target <= UNITY;
    end else begin
      // Raise the output on the final mix step, drop it once taken
      if (state == ST_MIXR && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WAVEFORM:   waveform   <= cfg_data[1:0];
          REG_PHASE_STEP: phase_step <= cfg_data;
          REG_GAIN:       gain       <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            left_in  <= in_data.left_in;
            right_in <= in_data.right_in;
            if (in_data.block_start) begin
              ramp_target <= in_data.soft_stop ? 16'd0 : UNITY;
              damping     <= in_data.soft_start ? 16'd0 : UNITY;
              ramp_dir    <= in_data.soft_start ? RAMP_UP :
                             (in_data.soft_stop ? RAMP_DOWN : RAMP_NONE);
            end
            state <= ST_WAVE;
          end
        end
        ST_WAVE:  state <= ST_MUL1;
        ST_MUL1:  state <= ST_MUL2;
        ST_MUL2:  state <= ST_SCALE;
        ST_SCALE: begin
          scaled  <= scaled_next;
          damping <= damping_next;
          phase   <= phase + PHASE_BITS'(phase_step);
          state   <= ST_MIXL;
        end
        ST_MIXL: begin
          left_sum <= mix_res;
          state    <= ST_MIXR;
        end
        ST_MIXR: begin
          if (out_free) begin
            out_data.left_out    <= left_sum;
            out_data.right_out   <= mix_res;
            out_data.wave_sample <= scaled;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while the sequencer stays ready");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    state != ST_SCALE |=> $stable(phase))
    else $error("phase moved outside the scale step");

  a_damping_range: assert property (@(posedge clk) disable iff (rst)
    damping <= UNITY)
    else $error("damping ramp left its range");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_MIXR))
    else $error("output loaded outside the final mix step");
`endif

endmodule
`default_nettype wire

[test/wosr_frame_checker.sv]
// ----------------------------------------------------------------------------
// wosr_frame_checker
// Predicts and checks the output frames of the soft-ramp waveform oscillator.
// ----------------------------------------------------------------------------
// Watches the input, output and register channels of the oscillator core.
// Each accepted input transaction goes through a local model of the phase
// accumulator, the four waveform shapes, the damping ramp, the gain and the
// saturating mix. The predicted frame is queued. Each accepted output
// transaction is compared field by field with the oldest predicted frame.
// ----------------------------------------------------------------------------
module wosr_frame_checker
  import wosr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [FIELD_BITS-1:0] cfg_data,
  output int                    mismatches,
  output int                    frames_due,
  output int                    frames_checked
);

  // Ramp directions
  localparam logic [1:0] RAMP_NONE = 2'd0;
  localparam logic [1:0] RAMP_UP   = 2'd1;
  localparam logic [1:0] RAMP_DOWN = 2'd2;

  localparam logic [FIELD_BITS-1:0] DEFAULT_STEP = 24'd153919;
  localparam longint unsigned Q30         = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint ROUND_HALF = 64'sd1 <<< 29;
  localparam longint MIX_HI     = (64'sd1 <<< (MIX_BITS - 1)) - 1;
  localparam longint MIX_LO     = -MIX_HI - 1;
  localparam int     FULL_SCALE = 32768;
  localparam logic [PHASE_BITS-1:0] HALF_TURN = {1'b1, {(PHASE_BITS-1){1'b0}}};

  int sine_lut [SINE_TABLE_DEPTH];

  // Oscillator state and register copies
  logic [PHASE_BITS-1:0] osc_phase;
  logic [15:0]           damp_level;
  logic [15:0]           ramp_goal;
  logic [1:0]            ramp_mode;
  logic [1:0]            wave_sel;
  logic [PHASE_BITS-1:0] phase_inc;
  logic [15:0]           gain_q15;

  out_item_t predicted_frames [$];

  // Sine of table entry idx in Q1.15 from a Q30 Taylor series on the quarter wave
  function automatic int sine_point(int unsigned idx);
    longint unsigned frac, ang, x, x2, t, s, v;
    int unsigned quad;
    frac = ({32'd0, idx} << 32) / SINE_TABLE_DEPTH;
    quad = int'(frac >> 30) & 3;
    ang = frac & (Q30 - 1);
    if (quad % 2 == 1) ang = Q30 - ang;
    x = (ang * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = Q30;
    for (int k = 0; k < 6; k++)
      t = Q30 - ((x2 * t) >> 30) / ((12 - 2 * k) * (13 - 2 * k));
    s = (x * t) >> 30;
    v = (s + 64'd16384) >> 15;
    return (quad >= 2) ? -int'(v) : int'(v);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advance the oscillator one frame tick and return the frame it produces
  function automatic out_item_t mix_oscillator_frame(in_item_t f);
    out_item_t r;
    int coarse, wave, gap, level;
    longint scaled, left_sum, right_sum;
    // Reload the ramp at block start; soft flags alone do nothing
    if (f.block_start) begin
      ramp_goal  = f.soft_stop  ? 16'd0 : UNITY;
      damp_level = f.soft_start ? 16'd0 : UNITY;
      if (f.soft_start)     ramp_mode = RAMP_UP;
      else if (f.soft_stop) ramp_mode = RAMP_DOWN;
      else                  ramp_mode = RAMP_NONE;
    end
    // Shape the waveform from the phase before this tick
    coarse = int'(osc_phase >> (PHASE_BITS - 16));
    case (wave_sel)
      WAVE_SINE:   wave = sine_lut[(64'(osc_phase) * SINE_TABLE_DEPTH) >> PHASE_BITS];
      WAVE_SAW:    wave = FULL_SCALE - coarse;
      WAVE_SQUARE: wave = (osc_phase <= HALF_TURN) ? FULL_SCALE : -FULL_SCALE;
      default: begin
        level = coarse - FULL_SCALE;
        if (level < 0) level = -level;
        wave = 2 * level - FULL_SCALE;
      end
    endcase
    // Scale by damping and gain, round half up, saturate to Q1.15
    scaled = (longint'(wave) * longint'(damp_level) * longint'(gain_q15) + ROUND_HALF) >>> 30;
    scaled = clamp(scaled, -32768, 32767);
    // Step the ramp only while at least one step away from its target
    gap = int'(ramp_goal) - int'(damp_level);
    if ((gap <= -int'(RAMP_STEP) || gap >= int'(RAMP_STEP)) &&
        (ramp_mode == RAMP_UP || ramp_mode == RAMP_DOWN)) begin
      level = int'(damp_level) + (ramp_mode == RAMP_UP ? int'(RAMP_STEP) : -int'(RAMP_STEP));
      damp_level = 16'(clamp(level, 0, 65535));
    end
    // Add the contribution into both channels with saturation
    left_sum  = clamp(longint'(f.left_in) + (scaled <<< (MIX_BITS - 16)), MIX_LO, MIX_HI);
    right_sum = clamp(longint'(f.right_in) + (scaled <<< (MIX_BITS - 16)), MIX_LO, MIX_HI);
    r.left_out    = left_sum[FIELD_BITS-1:0];
    r.right_out   = right_sum[FIELD_BITS-1:0];
    r.wave_sample = scaled[SAMPLE_BITS-1:0];
    osc_phase = osc_phase + phase_inc;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) sine_lut[i] = sine_point(i);
  end

  // Track register writes, predict on input, compare on output
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      osc_phase      = '0;
      damp_level     = UNITY;
      ramp_goal      = UNITY;
      ramp_mode      = RAMP_NONE;
      wave_sel       = WAVE_SINE;
      phase_inc      = DEFAULT_STEP;
      gain_q15       = UNITY;
      mismatches     = 0;
      frames_checked = 0;
      predicted_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WAVEFORM:   wave_sel  = cfg_data[1:0];
          REG_PHASE_STEP: phase_inc = cfg_data[PHASE_BITS-1:0];
          REG_GAIN:       gain_q15  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predicted_frames.push_back(mix_oscillator_frame(in_data));
      if (out_valid && out_ready) begin
        if (predicted_frames.size() == 0) begin
          $error("output transaction with no frame pending");
          mismatches++;
        end else begin
          want = predicted_frames.pop_front();
          frames_checked++;
          if (out_data.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
            mismatches++;
          end
          if (out_data.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, out_data.right_out);
            mismatches++;
          end
          if (out_data.wave_sample !== want.wave_sample) begin
            $error("wave_sample: expected %0d, got %0d", want.wave_sample,
                   out_data.wave_sample);
            mismatches++;
          end
        end
      end
    end
    frames_due = predicted_frames.size();
  end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the soft-ramp waveform oscillator core.
// ----------------------------------------------------------------------------
// Drives a short directed sequence (mix extremes, every waveform, soft start,
// soft stop, silent blocks, stray soft flags, square edge at half period),
// then random phases of block-structured frames under random register
// settings with random stalls on both channels. Registers are reprogrammed
// only after all frames of a phase have come back. A separate checker
// predicts and compares every frame.
// ----------------------------------------------------------------------------
module tb_top;
  import wosr_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_PHASES   = 11;
  localparam int PHASE_FRAMES  = 150;
  localparam int DIRECTED_TICKS = 10;
  localparam logic [FIELD_BITS-1:0] DEFAULT_STEP = 24'd153919;
  localparam logic [FIELD_BITS-1:0] HALF_PERIOD  = 24'd8388608;
  localparam logic signed [FIELD_BITS-1:0] MIX_MAX = 24'sh7FFFFF;
  localparam logic signed [FIELD_BITS-1:0] MIX_MIN = 24'sh800000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = REG_WAVEFORM;
  logic [FIELD_BITS-1:0] cfg_data = '0;

  int mismatches, frames_due, frames_checked;
  int frames_taken = 0;
  int writes_taken = 0;
  int quiet_cycles = 0;
  int sink_hold = 0;
  bit gaps_on = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  waveform_oscillator_soft_ramp_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wosr_frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .frames_due     (frames_due),
    .frames_checked (frames_checked)
  );

  // Count transactions and end the run if nothing moves for too long
  always @(posedge clk) begin
    if (in_valid && in_ready) frames_taken <= frames_taken + 1;
    if (cfg_valid && cfg_ready) writes_taken <= writes_taken + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Hold off the output channel in random bursts
  always @(negedge clk) begin
    if (!gaps_on) begin
      sink_hold = 0;
      out_ready <= 1'b1;
    end else begin
      if (sink_hold == 0 && $urandom_range(0, 9) == 0) sink_hold = $urandom_range(1, 17);
      if (sink_hold > 0) begin
        sink_hold = sink_hold - 1;
        out_ready <= 1'b0;
      end else
        out_ready <= 1'b1;
    end
  end

  function automatic logic signed [FIELD_BITS-1:0] mix_pick();
    case ($urandom_range(0, 7))
      0: return MIX_MAX;
      1: return MIX_MIN;
      2: return MIX_MAX - FIELD_BITS'($urandom_range(0, 4194304));
      3: return MIX_MIN + FIELD_BITS'($urandom_range(0, 4194304));
      default: return FIELD_BITS'($urandom());
    endcase
  endfunction

  // Present one frame, possibly after an idle burst, and wait for acceptance
  task automatic send_frame(in_item_t f);
    int goal;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    goal = frames_taken + 1;
    in_data  <= f;
    in_valid <= 1'b1;
    do @(negedge clk); while (frames_taken < goal);
  endtask

  task automatic tick(logic signed [FIELD_BITS-1:0] l, logic signed [FIELD_BITS-1:0] r,
                      logic bs, logic ss, logic sp);
    in_item_t f;
    f.left_in     = l;
    f.right_in    = r;
    f.block_start = bs;
    f.soft_start  = ss;
    f.soft_stop   = sp;
    send_frame(f);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [FIELD_BITS-1:0] val);
    int goal;
    goal = writes_taken + 1;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (writes_taken < goal);
  endtask

  task automatic program_regs(logic [1:0] shape, logic [FIELD_BITS-1:0] step,
                              logic [15:0] level);
    write_reg(REG_WAVEFORM, FIELD_BITS'(shape));
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_GAIN, FIELD_BITS'(level));
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every predicted frame, then let the pipeline settle
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (frames_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [FIELD_BITS-1:0] step_pick();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return HALF_PERIOD;
      2: return FIELD_BITS'($urandom_range(1, 64));
      3: return FIELD_BITS'($urandom_range(0, 8388608));
      default: return FIELD_BITS'($urandom_range(20000, 400000));
    endcase
  endfunction

  function automatic logic [15:0] gain_pick();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return UNITY;
      2: return 16'($urandom_range(0, 32768));
      default: return 16'($urandom_range(16384, 32768));
    endcase
  endfunction

  initial begin
    in_item_t f;
    int left, run;
    bit opener;
    logic [1:0] style;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: sine, default step, unity gain
    tick(MIX_MAX, MIX_MIN, 1'b0, 1'b0, 1'b0);
    tick(MIX_MAX, MIX_MIN, 1'b0, 1'b0, 1'b0);
    tick('0, '0, 1'b1, 1'b1, 1'b0);
    tick('0, '0, 1'b0, 1'b1, 1'b1);
    tick(MIX_MIN, MIX_MAX, 1'b0, 1'b0, 1'b0);
    tick('0, '0, 1'b1, 1'b0, 1'b1);
    tick('0, '0, 1'b0, 1'b0, 1'b0);
    tick('0, '0, 1'b1, 1'b1, 1'b1);
    tick('0, '0, 1'b0, 1'b0, 1'b0);
    tick('0, '0, 1'b1, 1'b0, 1'b0);
    drain_frames();

    // Square at full gain; the step lands the second frame exactly on half period
    program_regs(WAVE_SQUARE, HALF_PERIOD - FIELD_BITS'(DIRECTED_TICKS) * DEFAULT_STEP, UNITY);
    tick(MIX_MAX, MIX_MIN, 1'b0, 1'b0, 1'b0);
    tick(MIX_MAX, MIX_MIN, 1'b0, 1'b0, 1'b0);
    tick(MIX_MIN, MIX_MAX, 1'b0, 1'b0, 1'b0);
    tick(-24'sd1, 24'sd1, 1'b0, 1'b0, 1'b0);
    drain_frames();

    // Saw frozen at zero gain, triangle crawling, sine at the half-period step
    program_regs(WAVE_SAW, '0, 16'd0);
    tick(MIX_MAX, MIX_MIN, 1'b0, 1'b0, 1'b0);
    tick(MIX_MIN, MIX_MAX, 1'b1, 1'b0, 1'b0);
    drain_frames();
    program_regs(WAVE_TRIANGLE, 24'd1, 16'd32767);
    tick(MIX_MAX, MIX_MIN, 1'b0, 1'b0, 1'b0);
    tick(24'sd12345, -24'sd12345, 1'b0, 1'b0, 1'b0);
    drain_frames();
    program_regs(WAVE_SINE, HALF_PERIOD, 16'd16384);
    tick(MIX_MAX, MIX_MIN, 1'b0, 1'b0, 1'b0);
    tick(MIX_MIN, MIX_MAX, 1'b0, 1'b0, 1'b0);
    drain_frames();

    // Random phases of blocks; most open with a block start and a ramp request
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gaps_on <= (ph < RAND_PHASES - 1) && (ph % 3 != 2);
      program_regs(2'($urandom_range(0, 3)), step_pick(), gain_pick());
      left = PHASE_FRAMES;
      while (left > 0) begin
        run = $urandom_range(1, 70);
        if (run > left) run = left;
        opener = ($urandom_range(0, 5) != 0);
        style  = 2'($urandom_range(0, 3));
        for (int k = 0; k < run; k++) begin
          f.left_in  = mix_pick();
          f.right_in = mix_pick();
          if (k == 0 && opener) begin
            f.block_start = 1'b1;
            f.soft_start  = style[0];
            f.soft_stop   = style[1];
          end else begin
            f.block_start = ($urandom_range(0, 49) == 0);
            f.soft_start  = ($urandom_range(0, 3) == 0);
            f.soft_stop   = ($urandom_range(0, 3) == 0);
          end
          send_frame(f);
        end
        left -= run;
      end
      drain_frames();
    end

    $display("Run covered %0d frames and %0d register writes:", frames_taken, writes_taken);
    $display("all waveforms, ramps and mix saturation; %0d frames compared field by field.",
             frames_checked);
    if (mismatches == 0 && frames_due == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/wosr_pkg.sv
rtl/wosr_wave.sv
rtl/wosr_mul.sv
rtl/waveform_oscillator_soft_ramp_core.sv
test/wosr_frame_checker.sv
test/tb_top.sv
